### design/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define FFHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator check failed");

// clocked check, active through reset
`define FFHA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator reset check failed");

`endif

### design/ffha_pkg.sv
// types, codes and defaults of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int DEFAULT_DESCRIPTORS  = 64;
  localparam int DEFAULT_ADDRESS_BITS = 32;

  localparam logic [1:0] OP_ALLOC         = 2'd0;
  localparam logic [1:0] OP_ALLOC_ALIGNED = 2'd1;
  localparam logic [1:0] OP_FREE          = 2'd2;
  localparam logic [1:0] OP_COLLECT       = 2'd3;

  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_NO_SPARE     = 3'd1;
  localparam logic [2:0] STATUS_NO_FIT       = 3'd2;
  localparam logic [2:0] STATUS_UNKNOWN_ADDR = 3'd3;
  localparam logic [2:0] STATUS_BAD_ALIGN    = 3'd4;

  localparam logic [1:0] KIND_SPARE = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INUSE = 2'd2;

  localparam logic [1:0] REG_HEAP_START    = 2'd0;
  localparam logic [1:0] REG_HEAP_LENGTH   = 2'd1;
  localparam logic [1:0] REG_POINTER_BYTES = 2'd2;
  localparam logic [1:0] REG_WORD_BYTES    = 2'd3;

  localparam logic [31:0] RESET_HEAP_START    = 32'd0;
  localparam logic [31:0] RESET_HEAP_LENGTH   = 32'd65536;
  localparam logic [4:0]  RESET_POINTER_BYTES = 5'd8;
  localparam logic [3:0]  RESET_WORD_BYTES    = 4'd4;

  typedef struct packed {
    logic [31:0] heap_start;
    logic [31:0] heap_length;
    logic [4:0]  pointer_bytes;
    logic [3:0]  word_bytes;
    logic        rebuild;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] request_bytes;
    logic [4:0]  align_log2;
    logic [31:0] user_address;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [31:0] block_start;
    logic [32:0] block_bytes;
    logic [6:0]  merged_count;
  } result_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPARE_RD,
    ST_SPARE_CHK,
    ST_WALK_RD,
    ST_WALK_CAP,
    ST_WALK_PAD,
    ST_WALK_CMP,
    ST_ALLOC_W1,
    ST_ALLOC_W2,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_FREE_W,
    ST_SORT_RD,
    ST_SORT_CHK,
    ST_SORT_LINK,
    ST_MRG_RD,
    ST_MRG_CAP,
    ST_MRG_NRD,
    ST_MRG_NCHK,
    ST_MRG_W1,
    ST_MRG_W2,
    ST_DONE
  } state_t;

endpackage

### design/ffha_ram.sv
// generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ffha_cfg.sv
// configuration registers behind the register port
`timescale 1ns / 1ps
module ffha_cfg import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_start    <= RESET_HEAP_START;
      cfg.heap_length   <= RESET_HEAP_LENGTH;
      cfg.pointer_bytes <= RESET_POINTER_BYTES;
      cfg.word_bytes    <= RESET_WORD_BYTES;
      cfg.rebuild       <= 1'b0;
    end else begin
      cfg.rebuild <= wr;
      if (wr) begin
        unique case (paddr[3:2])
          REG_HEAP_START:    cfg.heap_start    <= pwdata;
          REG_HEAP_LENGTH:   cfg.heap_length   <= pwdata;
          REG_POINTER_BYTES: cfg.pointer_bytes <= pwdata[4:0];
          REG_WORD_BYTES:    cfg.word_bytes    <= pwdata[3:0];
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEAP_START:    prdata = cfg.heap_start;
      REG_HEAP_LENGTH:   prdata = cfg.heap_length;
      REG_POINTER_BYTES: prdata = {27'd0, cfg.pointer_bytes};
      REG_WORD_BYTES:    prdata = {28'd0, cfg.word_bytes};
    endcase
  end

endmodule

### design/ffha_core.sv
// descriptor table and command sequencer
`timescale 1ns / 1ps
module ffha_core import ffha_pkg::*; #(
  parameter int DESCRIPTORS  = DEFAULT_DESCRIPTORS,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    idle,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int AW = ADDRESS_BITS;
  localparam int IW = $clog2(DESCRIPTORS);
  localparam int LW = $clog2(DESCRIPTORS + 1);
  localparam int NW = ((AW > 33) ? AW : 33) + 1;
  localparam logic [LW-1:0] LINK_NULL = LW'(DESCRIPTORS);
  localparam logic [LW-1:0] LAST_IDX  = LW'(DESCRIPTORS - 1);

  state_t state, state_next;

  logic [LW-1:0] idx;
  logic [LW-1:0] head;
  logic [LW-1:0] cur, prev, steps, last, best;
  logic [IW-1:0] spare, nx_idx;
  logic [AW-1:0] uaddr, amask, user0, ua;
  logic [AW-1:0] cur_start, last_start, best_start;
  logic [32:0]   cur_len, nx_len, total;
  logic [LW-1:0] cur_next, nx_next;
  logic [5:0]    base;
  logic [NW-1:0] need;

  logic [IW-1:0] raddr, waddr;
  logic          we_start, we_len, we_ua, we_kind, we_next;
  logic [AW-1:0] wd_start, wd_ua, rd_start, rd_ua;
  logic [32:0]   wd_len, rd_len;
  logic [1:0]    wd_kind, rd_kind;
  logic [LW-1:0] wd_next, rd_next;

  logic align_bad, spare_hit, walk_end, fits, split, free_hit, sort_take;
  logic idx_last, touch, cur_null, next_null;
  logic [AW-1:0] pad;

  ffha_ram #(.WIDTH(AW), .DEPTH(DESCRIPTORS)) u_start (
    .clk(clk), .we(we_start), .waddr(waddr), .wdata(wd_start), .raddr(raddr), .rdata(rd_start)
  );
  ffha_ram #(.WIDTH(33), .DEPTH(DESCRIPTORS)) u_len (
    .clk(clk), .we(we_len), .waddr(waddr), .wdata(wd_len), .raddr(raddr), .rdata(rd_len)
  );
  ffha_ram #(.WIDTH(AW), .DEPTH(DESCRIPTORS)) u_ua (
    .clk(clk), .we(we_ua), .waddr(waddr), .wdata(wd_ua), .raddr(raddr), .rdata(rd_ua)
  );
  ffha_ram #(.WIDTH(2), .DEPTH(DESCRIPTORS)) u_kind (
    .clk(clk), .we(we_kind), .waddr(waddr), .wdata(wd_kind), .raddr(raddr), .rdata(rd_kind)
  );
  ffha_ram #(.WIDTH(LW), .DEPTH(DESCRIPTORS)) u_next (
    .clk(clk), .we(we_next), .waddr(waddr), .wdata(wd_next), .raddr(raddr), .rdata(rd_next)
  );

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign align_bad = (cmd.opcode == OP_ALLOC_ALIGNED) && (int'(cmd.align_log2) >= AW);
  assign spare_hit = (rd_kind == KIND_SPARE);
  assign walk_end  = (cur >= LINK_NULL) || (steps >= LINK_NULL);
  assign fits      = (NW'(cur_len) >= need);
  assign split     = (NW'(cur_len) > need);
  assign free_hit  = (rd_kind == KIND_INUSE) && (rd_ua == uaddr);
  assign idx_last  = (idx == LAST_IDX);
  assign touch     = ((NW'(cur_start) + NW'(cur_len)) == NW'(rd_start));
  assign cur_null  = (cur >= LINK_NULL);
  assign next_null = (cur_next >= LINK_NULL);
  assign pad       = (AW'(0) - user0) & amask;

  assign sort_take = (rd_kind == KIND_FREE)
    && ((last == LINK_NULL) || ({rd_start, idx[IW-1:0]} > {last_start, last[IW-1:0]}))
    && ((best == LINK_NULL) || ({rd_start, idx[IW-1:0]} < {best_start, best[IW-1:0]}));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (idx_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (cmd.opcode)
            OP_ALLOC:         state_next = ST_SPARE_RD;
            OP_ALLOC_ALIGNED: state_next = align_bad ? ST_DONE : ST_SPARE_RD;
            OP_FREE:          state_next = ST_FREE_RD;
            OP_COLLECT:       state_next = ST_SORT_RD;
          endcase
        end
      end
      ST_SPARE_RD:  state_next = ST_SPARE_CHK;
      ST_SPARE_CHK: begin
        if (spare_hit) state_next = ST_WALK_RD;
        else if (idx_last) state_next = ST_DONE;
        else state_next = ST_SPARE_RD;
      end
      ST_WALK_RD:   state_next = walk_end ? ST_DONE : ST_WALK_CAP;
      ST_WALK_CAP:  state_next = ST_WALK_PAD;
      ST_WALK_PAD:  state_next = ST_WALK_CMP;
      ST_WALK_CMP:  state_next = fits ? ST_ALLOC_W1 : ST_WALK_RD;
      ST_ALLOC_W1:  state_next = ST_ALLOC_W2;
      ST_ALLOC_W2:  state_next = ST_DONE;
      ST_FREE_RD:   state_next = ST_FREE_CHK;
      ST_FREE_CHK: begin
        if (free_hit) state_next = ST_FREE_W;
        else if (idx_last) state_next = ST_DONE;
        else state_next = ST_FREE_RD;
      end
      ST_FREE_W:    state_next = ST_DONE;
      ST_SORT_RD:   state_next = ST_SORT_CHK;
      ST_SORT_CHK:  state_next = idx_last ? ST_SORT_LINK : ST_SORT_RD;
      ST_SORT_LINK: state_next = (best != LINK_NULL) ? ST_SORT_RD : ST_MRG_RD;
      ST_MRG_RD:    state_next = cur_null ? ST_DONE : ST_MRG_CAP;
      ST_MRG_CAP:   state_next = ST_MRG_NRD;
      ST_MRG_NRD:   state_next = next_null ? ST_DONE : ST_MRG_NCHK;
      ST_MRG_NCHK:  state_next = touch ? ST_MRG_W1 : ST_MRG_NRD;
      ST_MRG_W1:    state_next = ST_MRG_W2;
      ST_MRG_W2:    state_next = ST_MRG_NRD;
      ST_DONE:      if (res_ready) state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
    if (cfg.rebuild) begin
      state_next = ST_CLEAR;
    end
  end

  // table access
  always_comb begin
    raddr    = idx[IW-1:0];
    waddr    = idx[IW-1:0];
    we_start = 1'b0;
    we_len   = 1'b0;
    we_ua    = 1'b0;
    we_kind  = 1'b0;
    we_next  = 1'b0;
    wd_start = '0;
    wd_len   = '0;
    wd_ua    = '0;
    wd_kind  = KIND_SPARE;
    wd_next  = LINK_NULL;
    unique case (state)
      ST_CLEAR: begin
        {we_start, we_len, we_ua, we_kind, we_next} = '1;
        if (idx == '0) begin
          wd_start = AW'(cfg.heap_start);
          wd_len   = 33'(cfg.heap_length);
          wd_kind  = KIND_FREE;
        end
      end
      ST_WALK_RD, ST_MRG_RD: raddr = cur[IW-1:0];
      ST_MRG_NRD:            raddr = cur_next[IW-1:0];
      ST_ALLOC_W1: begin
        waddr = split ? spare : cur[IW-1:0];
        {we_start, we_len, we_ua, we_kind, we_next} = '1;
        wd_start = cur_start;
        wd_len   = need[32:0];
        wd_ua    = ua;
        wd_kind  = KIND_INUSE;
      end
      ST_ALLOC_W2: begin
        if (split) begin
          waddr    = cur[IW-1:0];
          we_start = 1'b1;
          we_len   = 1'b1;
          wd_start = cur_start + AW'(need);
          wd_len   = cur_len - need[32:0];
        end else begin
          waddr   = prev[IW-1:0];
          we_next = (prev != LINK_NULL);
          wd_next = cur_next;
        end
      end
      ST_FREE_W: begin
        we_kind = 1'b1;
        we_ua   = 1'b1;
        we_next = 1'b1;
        wd_kind = KIND_FREE;
        wd_next = head;
      end
      ST_SORT_LINK: begin
        waddr   = last[IW-1:0];
        we_next = (last != LINK_NULL);
        wd_next = best;
      end
      ST_MRG_W1: begin
        waddr   = cur[IW-1:0];
        we_len  = 1'b1;
        we_next = 1'b1;
        wd_len  = cur_len + nx_len;
        wd_next = nx_next;
      end
      ST_MRG_W2: begin
        waddr = nx_idx;
        {we_start, we_len, we_ua, we_kind, we_next} = '1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (cfg.rebuild) begin
        idx <= '0;
      end else begin
        unique case (state)
          ST_CLEAR, ST_SPARE_CHK, ST_SORT_CHK: idx <= idx + 1'b1;
          ST_FREE_CHK: if (!free_hit) idx <= idx + 1'b1;
          ST_IDLE, ST_SORT_LINK: idx <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_CLEAR: head <= '0;
      ST_IDLE: begin
        if (start) begin
          uaddr <= AW'(cmd.user_address);
          base  <= 6'(cfg.pointer_bytes) + 6'(cfg.word_bytes);
          total <= 33'(cmd.request_bytes) + 33'(cfg.pointer_bytes)
                   + 33'(cfg.word_bytes) + 33'(cfg.word_bytes);
          amask <= (cmd.opcode == OP_ALLOC_ALIGNED) ? ~({AW{1'b1}} << cmd.align_log2) : '0;
          res   <= '{status: (align_bad ? STATUS_BAD_ALIGN : STATUS_OK), default: '0};
          last  <= LINK_NULL;
          best  <= LINK_NULL;
          if (cmd.opcode == OP_COLLECT) head <= LINK_NULL;
        end
      end
      ST_SPARE_CHK: begin
        if (spare_hit) begin
          spare <= idx[IW-1:0];
          cur   <= head;
          prev  <= LINK_NULL;
          steps <= '0;
        end else if (idx_last) begin
          res.status <= STATUS_NO_SPARE;
        end
      end
      ST_WALK_RD: if (walk_end) res.status <= STATUS_NO_FIT;
      ST_WALK_CAP: begin
        cur_start <= rd_start;
        cur_len   <= rd_len;
        cur_next  <= rd_next;
        user0     <= rd_start + AW'(base);
      end
      ST_WALK_PAD: begin
        need <= NW'(total) + NW'(pad);
        ua   <= user0 + pad;
      end
      ST_WALK_CMP: begin
        if (!fits) begin
          prev  <= cur;
          cur   <= cur_next;
          steps <= steps + 1'b1;
        end
      end
      ST_ALLOC_W1: begin
        res.result_address <= 32'(ua);
        res.block_start    <= 32'(cur_start);
        res.block_bytes    <= need[32:0];
      end
      ST_ALLOC_W2: if (!split && (prev == LINK_NULL)) head <= cur_next;
      ST_FREE_CHK: begin
        if (free_hit) begin
          res.block_start <= 32'(rd_start);
          res.block_bytes <= rd_len;
        end else if (idx_last) begin
          res.status <= STATUS_UNKNOWN_ADDR;
        end
      end
      ST_FREE_W: head <= idx;
      ST_SORT_CHK: begin
        if (sort_take) begin
          best       <= idx;
          best_start <= rd_start;
        end
      end
      ST_SORT_LINK: begin
        if (best != LINK_NULL) begin
          if (last == LINK_NULL) head <= best;
          last       <= best;
          last_start <= best_start;
          best       <= LINK_NULL;
        end else begin
          cur <= head;
        end
      end
      ST_MRG_CAP: begin
        cur_start <= rd_start;
        cur_len   <= rd_len;
        cur_next  <= rd_next;
      end
      ST_MRG_NCHK: begin
        nx_idx  <= cur_next[IW-1:0];
        nx_len  <= rd_len;
        nx_next <= rd_next;
        if (!touch) begin
          cur       <= cur_next;
          cur_start <= rd_start;
          cur_len   <= rd_len;
          cur_next  <= rd_next;
        end
      end
      ST_MRG_W1: begin
        cur_len  <= cur_len + nx_len;
        cur_next <= nx_next;
      end
      ST_MRG_W2: begin
        if (res.merged_count != 7'd127) res.merged_count <= res.merged_count + 7'd1;
      end
      default: ;
    endcase
  end

endmodule

### design/first_fit_heap_allocator.sv
// top level: first-fit heap allocator with stream command and result ports
// Each command word on the input stream runs to completion before the next is taken;
// the descriptor table lives in single-port-read memories, so every table visit goes
// through a registered read. After reset and after any register write the table is
// rebuilt as one free block in a clearing pass over all descriptors with the input not
// ready. Allocate scans the table for a spare descriptor, then walks the free list one
// block at a time and commits in the write states ST_ALLOC_W1 and ST_ALLOC_W2. Free
// scans the table entry by entry. Collect sorts by repeated minimum search, one search
// over the table per free block plus one final pass, then walks the sorted list and
// merges touching neighbours. A result word is held in an output register, so a
// new command is taken while the previous result still waits.
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int DESCRIPTORS  = DEFAULT_DESCRIPTORS,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // request_bytes, align_log2, user_address, zero fill
  input  logic [1:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // result_address, block_start, block_bytes, merged_count
  output logic [2:0]   m_axis_tuser,  // status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  result_t res;
  logic    core_idle, start, res_valid, res_ready;

  ffha_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign cmd.opcode        = s_axis_tuser;
  assign cmd.request_bytes = s_axis_tdata[31:0];
  assign cmd.align_log2    = s_axis_tdata[36:32];
  assign cmd.user_address  = s_axis_tdata[68:37];

  assign s_axis_tready = core_idle & ~cfg.rebuild;
  assign start         = s_axis_tvalid & s_axis_tready;
  assign res_ready     = ~m_axis_tvalid | m_axis_tready;

  ffha_core #(.DESCRIPTORS(DESCRIPTORS), .ADDRESS_BITS(ADDRESS_BITS)) u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .cmd(cmd), .idle(core_idle),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tuser <= res.status;
      m_axis_tdata <= {res.merged_count, res.block_bytes, res.block_start,
                       res.result_address};
    end
  end

endmodule

### design/ffha_checker.sv
// port-level checks of the allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffha_props import ffha_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [71:0]  s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [3:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  logic out_stall, out_same, in_take, cfg_wr;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign cfg_wr    = psel && penable && pwrite && pready;

  `FFHA_ASSERT(out_hold, out_stall |=> m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))
  `FFHA_ASSERT(busy_after_cmd, in_take |=> !s_axis_tready)
  `FFHA_ASSERT(fail_fields_zero, m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tdata == '0)
  `FFHA_ASSERT(rebuild_blocks, cfg_wr |=> !s_axis_tready)
  `FFHA_ASSERT_RST(reset_quiet, rst |=> !m_axis_tvalid && !s_axis_tready)

endmodule

bind first_fit_heap_allocator ffha_props u_ffha_props (.*);

### verif/ffha_checker.sv
// checker for the first-fit heap allocator: predicts each result word and compares it
`timescale 1ns / 1ps
module ffha_checker import ffha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           errors,
  output int           pending
);

  localparam int NDESC = 64;
  localparam longint unsigned AMASK = 64'hFFFF_FFFF;
  localparam longint unsigned LMASK = 64'h1_FFFF_FFFF;

  longint unsigned heap_base, heap_len, ptr_bytes, guard_bytes;
  longint unsigned blk_start [NDESC];
  longint unsigned blk_len   [NDESC];
  longint unsigned blk_user  [NDESC];
  logic [1:0]      blk_kind  [NDESC];
  int              blk_next  [NDESC];
  int              list_head;
  result_t         expected_results [$];

  function automatic void clear_slot(int i);
    blk_start[i] = 0;
    blk_len[i]   = 0;
    blk_user[i]  = 0;
    blk_kind[i]  = KIND_SPARE;
    blk_next[i]  = NDESC;
  endfunction

  function automatic void rebuild_table();
    for (int i = 0; i < NDESC; i++) clear_slot(i);
    blk_start[0] = heap_base & AMASK;
    blk_len[0]   = heap_len & LMASK;
    blk_kind[0]  = KIND_FREE;
    list_head    = 0;
  endfunction

  function automatic result_t allocate(logic aligned, longint unsigned req, int alg);
    result_t r;
    longint unsigned base, total, amask, pad, need, user0, blk;
    int spare, cur, prev, steps, tgt;
    r = '0;
    base = ptr_bytes + guard_bytes;
    total = base + guard_bytes + req;
    amask = 0;
    pad = 0;
    need = 0;
    prev = NDESC;
    steps = 0;
    if (aligned) begin
      if (alg >= 32) begin
        r.status = STATUS_BAD_ALIGN;
        return r;
      end
      amask = (64'd1 << alg) - 1;
    end
    spare = NDESC;
    for (int i = NDESC - 1; i >= 0; i--) if (blk_kind[i] == KIND_SPARE) spare = i;
    if (spare == NDESC) begin
      r.status = STATUS_NO_SPARE;
      return r;
    end
    cur = list_head;
    while (cur < NDESC && steps < NDESC) begin
      user0 = (blk_start[cur] + base) & AMASK;
      pad = aligned ? (((amask + 1) - (user0 & amask)) & amask) : 0;
      need = total + pad;
      if (blk_len[cur] >= need) break;
      prev = cur;
      cur = blk_next[cur];
      steps++;
    end
    if (cur >= NDESC || steps >= NDESC) begin
      r.status = STATUS_NO_FIT;
      return r;
    end
    blk = blk_start[cur];
    if (blk_len[cur] > need) begin
      blk_start[cur] = (blk + need) & AMASK;
      blk_len[cur] = (blk_len[cur] - need) & LMASK;
      tgt = spare;
    end else begin
      if (prev == NDESC) list_head = blk_next[cur];
      else blk_next[prev] = blk_next[cur];
      tgt = cur;
    end
    blk_kind[tgt]  = KIND_INUSE;
    blk_start[tgt] = blk;
    blk_len[tgt]   = need & LMASK;
    blk_user[tgt]  = (blk + pad + base) & AMASK;
    blk_next[tgt]  = NDESC;
    r.status = STATUS_OK;
    r.result_address = blk_user[tgt][31:0];
    r.block_start = blk[31:0];
    r.block_bytes = need[32:0];
    return r;
  endfunction

  function automatic result_t release_block(longint unsigned addr);
    result_t r;
    r = '0;
    for (int i = 0; i < NDESC; i++) begin
      if (blk_kind[i] == KIND_INUSE && blk_user[i] == addr) begin
        blk_kind[i] = KIND_FREE;
        blk_user[i] = 0;
        blk_next[i] = list_head;
        list_head = i;
        r.block_start = blk_start[i][31:0];
        r.block_bytes = blk_len[i][32:0];
        return r;
      end
    end
    r.status = STATUS_UNKNOWN_ADDR;
    return r;
  endfunction

  function automatic result_t coalesce();
    result_t r;
    bit placed [NDESC];
    int tail, cur, nx, best, merged;
    r = '0;
    tail = NDESC;
    merged = 0;
    for (int i = 0; i < NDESC; i++) placed[i] = 0;
    list_head = NDESC;
    forever begin
      best = NDESC;
      for (int i = 0; i < NDESC; i++)
        if (blk_kind[i] == KIND_FREE && !placed[i])
          if (best == NDESC || blk_start[i] < blk_start[best]) best = i;
      if (best == NDESC) break;
      placed[best] = 1;
      blk_next[best] = NDESC;
      if (tail == NDESC) list_head = best;
      else blk_next[tail] = best;
      tail = best;
    end
    cur = list_head;
    while (cur < NDESC) begin
      nx = blk_next[cur];
      if (nx >= NDESC) break;
      if (blk_start[cur] + blk_len[cur] == blk_start[nx]) begin
        blk_len[cur] = (blk_len[cur] + blk_len[nx]) & LMASK;
        blk_next[cur] = blk_next[nx];
        clear_slot(nx);
        if (merged < 127) merged++;
      end else begin
        cur = nx;
      end
    end
    r.merged_count = merged[6:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t got, want;
    int bad;
    bad = 0;
    if (rst) begin
      heap_base = 64'(RESET_HEAP_START);
      heap_len = 64'(RESET_HEAP_LENGTH);
      ptr_bytes = 64'(RESET_POINTER_BYTES);
      guard_bytes = 64'(RESET_WORD_BYTES);
      rebuild_table();
      expected_results.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_HEAP_START:    heap_base = 64'(pwdata);
          REG_HEAP_LENGTH:   heap_len = 64'(pwdata);
          REG_POINTER_BYTES: ptr_bytes = 64'(pwdata[4:0]);
          REG_WORD_BYTES:    guard_bytes = 64'(pwdata[3:0]);
        endcase
        rebuild_table();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_ALLOC:         want = allocate(1'b0, 64'(s_axis_tdata[31:0]), 0);
          OP_ALLOC_ALIGNED: want = allocate(1'b1, 64'(s_axis_tdata[31:0]),
                                            int'(s_axis_tdata[36:32]));
          OP_FREE:          want = release_block(64'(s_axis_tdata[68:37]));
          default:          want = coalesce();
        endcase
        expected_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.result_address = m_axis_tdata[31:0];
        got.block_start = m_axis_tdata[63:32];
        got.block_bytes = m_axis_tdata[96:64];
        got.merged_count = m_axis_tdata[103:97];
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          bad++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            bad++;
          end
          if (got.result_address !== want.result_address) begin
            $error("result_address expected %0h got %0h", want.result_address,
                   got.result_address);
            bad++;
          end
          if (got.block_start !== want.block_start) begin
            $error("block_start expected %0h got %0h", want.block_start, got.block_start);
            bad++;
          end
          if (got.block_bytes !== want.block_bytes) begin
            $error("block_bytes expected %0h got %0h", want.block_bytes, got.block_bytes);
            bad++;
          end
          if (got.merged_count !== want.merged_count) begin
            $error("merged_count expected %0d got %0d", want.merged_count,
                   got.merged_count);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

### verif/tb.sv
// testbench top for the first-fit heap allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb;
  import ffha_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // request_bytes, align_log2, user_address, zero fill
  logic [1:0]   s_axis_tuser = '0;   // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // result_address, block_start, block_bytes, merged_count
  logic [2:0]   m_axis_tuser;        // status
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int      errors;
  int      pending;
  longint  cycles = 0;
  bit      steady = 0;
  bit      hold_req = 0;
  bit      hold_done = 0;
  int      hold_left = 0;
  logic [31:0] live_addrs [$];

  first_fit_heap_allocator i_dut (.*);

  ffha_checker i_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  // remember granted addresses for later frees
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tuser == STATUS_OK &&
        m_axis_tdata[31:0] != 0)
      live_addrs.push_back(m_axis_tdata[31:0]);
  end

  task automatic send_word(logic [1:0] op, logic [31:0] req, logic [4:0] alg,
                           logic [31:0] ua);
    while (!steady && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, ua, alg, req};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_heap(logic [31:0] st, logic [31:0] len, logic [31:0] pb, logic [31:0] wb);
    drain();
    reg_write(REG_HEAP_START, st);
    reg_write(REG_HEAP_LENGTH, len);
    reg_write(REG_POINTER_BYTES, pb);
    reg_write(REG_WORD_BYTES, wb);
    live_addrs.delete();
  endtask

  task automatic free_live();
    int k;
    logic [31:0] a;
    if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0) begin
      send_word(OP_FREE, $urandom, 5'($urandom), $urandom);
    end else begin
      k = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[k];
      live_addrs.delete(k);
      send_word(OP_FREE, $urandom, 5'($urandom), a);
    end
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) send_word(OP_ALLOC, $urandom_range(0, 600), 5'($urandom), $urandom);
    else if (pick < 52)
      send_word(OP_ALLOC_ALIGNED, $urandom_range(0, 300), 5'($urandom_range(0, 12)), $urandom);
    else if (pick < 55)
      send_word(OP_ALLOC_ALIGNED, $urandom_range(0, 300), 5'($urandom_range(13, 31)),
                $urandom);
    else if (pick < 58) send_word(OP_ALLOC, $urandom, 5'($urandom), $urandom);
    else if (pick < 94) free_live();
    else send_word(OP_COLLECT, $urandom, 5'($urandom), $urandom);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) random_word();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: size and alignment extremes
    send_word(OP_ALLOC, 32'd0, 5'd0, 32'd0);
    send_word(OP_ALLOC, 32'd100, 5'd0, 32'd0);
    send_word(OP_ALLOC_ALIGNED, 32'd5, 5'd0, 32'd0);
    send_word(OP_ALLOC_ALIGNED, 32'd40, 5'd12, 32'd0);
    send_word(OP_ALLOC_ALIGNED, 32'd1, 5'd31, 32'd0);
    send_word(OP_ALLOC, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_word(OP_FREE, 32'd0, 5'd0, 32'h0001_2345);
    drain();
    while (live_addrs.size() != 0) free_live();
    send_word(OP_COLLECT, 32'd0, 5'd0, 32'd0);

    // exact fit takes the only block, then collect with an empty list
    set_heap(32'd0, 32'd100, 32'd8, 32'd4);
    send_word(OP_ALLOC, 32'd84, 5'd0, 32'd0);
    send_word(OP_COLLECT, 32'd0, 5'd0, 32'd0);
    send_word(OP_ALLOC, 32'd0, 5'd0, 32'd0);
    send_word(OP_FREE, 32'd0, 5'd0, 32'd16);
    send_word(OP_COLLECT, 32'd0, 5'd0, 32'd0);

    // wrapping addresses and widest register values
    set_heap(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd31, 32'd15);
    random_run(150);

    set_heap(32'h0000_1000, 32'd0, 32'd0, 32'd0);
    random_run(40);

    set_heap(32'h2000_0000, 32'd20000, 32'd1, 32'd1);
    random_run(150);
    hold_req <= 1'b1;
    random_run(150);

    set_heap(32'h0000_0040, 32'd65536, 32'd16, 32'd8);
    random_run(100);
    steady <= 1'b1;
    random_run(120);
    steady <= 1'b0;
    random_run(80);

    // descriptor exhaustion, then mixed traffic
    set_heap(32'd0, 32'd65536, 32'd8, 32'd4);
    for (int i = 0; i < 70; i++) send_word(OP_ALLOC, $urandom_range(0, 64), 5'd0, 32'd0);
    random_run(180);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
